@@ design/indexed_binary_heap_queue_unit_macros.svh @@
// Assertion helpers used by the heap queue design file.
`ifndef INDEXED_BINARY_HEAP_QUEUE_UNIT_MACROS_SVH
`define INDEXED_BINARY_HEAP_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define IBHQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heap queue check failed");

// Next-cycle implication, sampled on clk and disabled while in reset.
`define IBHQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heap queue check failed");

`endif

@@ design/ibhq_pkg.sv @@
package ibhq_pkg;

  localparam int unsigned DEF_MAX_ENTRIES = 64;
  localparam int unsigned DEF_KEY_BITS    = 32;
  localparam int unsigned ID_BITS         = 6;
  localparam int unsigned ID_SPACE        = 64;
  localparam int unsigned KIND_BITS       = 3;
  localparam int unsigned PORT_KEY_BITS   = 32;
  localparam int unsigned CAP_BITS        = 7;
  localparam int unsigned CFG_IDX_BITS    = 1;
  localparam int unsigned COUNT_OUT_BITS  = 7;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_INSERT = 3'd0,
    KIND_CHANGE = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_DELTOP = 3'd3,
    KIND_READ   = 3'd4,
    KIND_PEEK   = 3'd5
  } kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CAPACITY = 1'b0,
    REG_MIN_HEAP = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_RDKEY,
    ST_CHG,
    ST_RMV,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_LOAD,
    ST_DN_GET,
    ST_DN_RD,
    ST_DN_SEL,
    ST_DN_CMP,
    ST_DONE
  } state_t;

endpackage

@@ design/ibhq_in_if.sv @@
interface ibhq_in_if;
  logic                                       valid;
  logic                                       ready;
  logic [ibhq_pkg::KIND_BITS-1:0]             kind;
  logic [ibhq_pkg::ID_BITS-1:0]               entry_id;
  logic signed [ibhq_pkg::PORT_KEY_BITS-1:0]  key;

  modport source (output valid, kind, entry_id, key, input ready);
  modport sink (input valid, kind, entry_id, key, output ready);
endinterface

@@ design/ibhq_out_if.sv @@
interface ibhq_out_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       ok;
  logic [ibhq_pkg::ID_BITS-1:0]               found_id;
  logic signed [ibhq_pkg::PORT_KEY_BITS-1:0]  found_key;
  logic                                       top_valid;
  logic [ibhq_pkg::ID_BITS-1:0]               top_id;
  logic signed [ibhq_pkg::PORT_KEY_BITS-1:0]  top_key;
  logic [ibhq_pkg::COUNT_OUT_BITS-1:0]        entry_count;

  modport source (output valid, ok, found_id, found_key, top_valid, top_id, top_key,
                  entry_count, input ready);
  modport sink (input valid, ok, found_id, found_key, top_valid, top_id, top_key,
                entry_count, output ready);
endinterface

@@ design/indexed_binary_heap_queue_unit.sv @@
// Indexed binary heap priority queue. Each transfer on in_chan runs one operation
// (insert, change key, remove id, delete top, read key, peek) and gives exactly one
// transfer on out_chan. One operation at a time: in_chan.ready is high only while
// the sequencer is idle. Reads and peeks need no sift; insert walks up the heap,
// change walks up or down, and remove and delete top fill the hole with the last
// entry, walk it up and then down. Each level up passes ST_UP_RD and ST_UP_CMP, and
// each level down ST_DN_RD, ST_DN_SEL and ST_DN_CMP. The rate is set by the single
// comparator and the single write port of the heap memory, both shared by every sift
// step. The id presence map clears at reset; no clearing pass is needed.
module indexed_binary_heap_queue_unit #(
  parameter int unsigned MAX_ENTRIES = ibhq_pkg::DEF_MAX_ENTRIES,
  parameter int unsigned KEY_BITS    = ibhq_pkg::DEF_KEY_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  ibhq_in_if.sink                               in_chan,
  ibhq_out_if.source                            out_chan,
  input  logic                                  cfg_we,
  input  logic [ibhq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [ibhq_pkg::CAP_BITS-1:0]         cfg_wdata
);

  localparam int unsigned SW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LW = CW + 1;
  localparam int unsigned IW = ibhq_pkg::ID_BITS;

  typedef struct packed {
    logic [IW-1:0]              id;
    logic signed [KEY_BITS-1:0] key;
  } entry_t;

  function automatic logic ranks_above(input logic mn, input logic signed [KEY_BITS-1:0] a,
                                       input logic signed [KEY_BITS-1:0] b);
    ranks_above = mn ? (a < b) : (b < a);
  endfunction

  entry_t heap_mem [MAX_ENTRIES];
  logic [SW-1:0] slot_mem [ibhq_pkg::ID_SPACE];

  ibhq_pkg::state_t st_r, st_nxt;
  ibhq_pkg::kind_t kind_r, kind_nxt;
  logic [IW-1:0] id_r, id_nxt;
  logic signed [KEY_BITS-1:0] key_r, key_nxt;
  logic [SW-1:0] s_r, s_nxt, s0_r, s0_nxt, chidx_r, chidx_nxt;
  entry_t cur_r, cur_nxt, ch_r, ch_nxt, top_r, rd_a_r, rd_b_r;
  logic [CW-1:0] count_r, count_nxt;
  logic down_after_r, down_after_nxt;
  logic [ibhq_pkg::ID_SPACE-1:0] present_r, present_nxt;
  logic [ibhq_pkg::CAP_BITS-1:0] cap_r;
  logic min_r;
  logic ok_r, ok_nxt;
  logic [IW-1:0] fid_r, fid_nxt;
  logic signed [KEY_BITS-1:0] fkey_r, fkey_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_ok_r, out_top_valid_r;
  logic [IW-1:0] out_fid_r, out_top_id_r;
  logic signed [ibhq_pkg::PORT_KEY_BITS-1:0] out_fkey_r, out_top_key_r;
  logic [ibhq_pkg::COUNT_OUT_BITS-1:0] out_count_r;
  logic out_load;

  logic wr_en, swr_en;
  logic [SW-1:0] wr_addr, ra_addr, rb_addr, swr_data;
  entry_t wr_data;
  logic [IW-1:0] swr_addr, sr_addr;
  logic [SW-1:0] sr_data_r;

  logic id_ok, pres, slot_ok;
  logic [LW-1:0] lchild;
  logic [SW-1:0] last;
  logic rvalid, pick_right;
  logic signed [KEY_BITS-1:0] cmp_a, cmp_b;
  logic cmp_above;

  assign in_chan.ready = (st_r == ibhq_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_a_r <= heap_mem[ra_addr];
    rd_b_r <= heap_mem[rb_addr];
  end

  always_ff @(posedge clk) begin
    if (swr_en) begin
      slot_mem[swr_addr] <= swr_data;
    end
    sr_data_r <= slot_mem[sr_addr];
  end

  // One key comparator, its operands steered by the sequencer state.
  always_comb begin
    case (st_r)
      ibhq_pkg::ST_CHG: begin
        cmp_a = key_r;
        cmp_b = rd_a_r.key;
      end
      ibhq_pkg::ST_DN_SEL: begin
        cmp_a = rd_a_r.key;
        cmp_b = rd_b_r.key;
      end
      ibhq_pkg::ST_DN_CMP: begin
        cmp_a = ch_r.key;
        cmp_b = cur_r.key;
      end
      default: begin
        cmp_a = cur_r.key;
        cmp_b = rd_a_r.key;
      end
    endcase
    cmp_above = ranks_above(min_r, cmp_a, cmp_b);
  end

  always_comb begin
    id_ok      = (id_r < cap_r) && (32'(id_r) < MAX_ENTRIES);
    pres       = present_r[id_r];
    slot_ok    = (CW'(sr_data_r) < count_r);
    lchild     = LW'({s_r, 1'b0}) + LW'(1);
    last       = SW'(count_r - CW'(1));
    rvalid     = (lchild + LW'(1)) < LW'(count_r);
    pick_right = rvalid && !cmp_above;
  end

  always_comb begin
    st_nxt         = st_r;
    kind_nxt       = kind_r;
    id_nxt         = id_r;
    key_nxt        = key_r;
    s_nxt          = s_r;
    s0_nxt         = s0_r;
    chidx_nxt      = chidx_r;
    cur_nxt        = cur_r;
    ch_nxt         = ch_r;
    count_nxt      = count_r;
    down_after_nxt = down_after_r;
    present_nxt    = present_r;
    ok_nxt         = ok_r;
    fid_nxt        = fid_r;
    fkey_nxt       = fkey_r;
    out_load       = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = s_r;
    wr_data        = cur_r;
    swr_en         = 1'b0;
    swr_addr       = cur_r.id;
    swr_data       = s_r;
    ra_addr        = s_r;
    rb_addr        = s_r;
    sr_addr        = in_chan.entry_id;

    unique case (st_r)
      ibhq_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          kind_nxt = ibhq_pkg::kind_t'(in_chan.kind);
          id_nxt   = in_chan.entry_id;
          key_nxt  = KEY_BITS'(in_chan.key);
          ok_nxt   = 1'b0;
          fid_nxt  = '0;
          fkey_nxt = '0;
          st_nxt   = ibhq_pkg::ST_LOOK;
        end
      end
      ibhq_pkg::ST_LOOK: begin
        st_nxt         = ibhq_pkg::ST_DONE;
        down_after_nxt = 1'b0;
        case (kind_r)
          ibhq_pkg::KIND_INSERT: begin
            if (id_ok && !pres && (count_r < CW'(MAX_ENTRIES))) begin
              cur_nxt              = '{id: id_r, key: key_r};
              s_nxt                = SW'(count_r);
              count_nxt            = count_r + CW'(1);
              present_nxt[id_r]    = 1'b1;
              ok_nxt               = 1'b1;
              st_nxt               = ibhq_pkg::ST_UP_RD;
            end
          end
          ibhq_pkg::KIND_CHANGE: begin
            if (id_ok && pres && slot_ok) begin
              s_nxt   = sr_data_r;
              ra_addr = sr_data_r;
              ok_nxt  = 1'b1;
              st_nxt  = ibhq_pkg::ST_CHG;
            end
          end
          ibhq_pkg::KIND_REMOVE: begin
            if (id_ok && pres && slot_ok) begin
              s_nxt             = sr_data_r;
              s0_nxt            = sr_data_r;
              present_nxt[id_r] = 1'b0;
              ra_addr           = last;
              ok_nxt            = 1'b1;
              st_nxt            = ibhq_pkg::ST_RMV;
            end
          end
          ibhq_pkg::KIND_DELTOP: begin
            if (count_r != '0) begin
              fid_nxt                 = top_r.id;
              fkey_nxt                = top_r.key;
              present_nxt[top_r.id]   = 1'b0;
              s_nxt                   = '0;
              s0_nxt                  = '0;
              ra_addr                 = last;
              ok_nxt                  = 1'b1;
              st_nxt                  = ibhq_pkg::ST_RMV;
            end
          end
          ibhq_pkg::KIND_READ: begin
            if (id_ok && pres && slot_ok) begin
              ra_addr = sr_data_r;
              ok_nxt  = 1'b1;
              st_nxt  = ibhq_pkg::ST_RDKEY;
            end
          end
          ibhq_pkg::KIND_PEEK: begin
            ok_nxt = (count_r != '0);
          end
          default: begin
          end
        endcase
      end
      ibhq_pkg::ST_RDKEY: begin
        fkey_nxt = rd_a_r.key;
        st_nxt   = ibhq_pkg::ST_DONE;
      end
      ibhq_pkg::ST_CHG: begin
        cur_nxt = '{id: id_r, key: key_r};
        st_nxt  = cmp_above ? ibhq_pkg::ST_UP_RD : ibhq_pkg::ST_DN_RD;
      end
      ibhq_pkg::ST_RMV: begin
        count_nxt = count_r - CW'(1);
        if (s_r == last) begin
          st_nxt = ibhq_pkg::ST_DONE;
        end else begin
          cur_nxt        = rd_a_r;
          down_after_nxt = 1'b1;
          st_nxt         = ibhq_pkg::ST_UP_RD;
        end
      end
      ibhq_pkg::ST_UP_RD: begin
        if (s_r == '0) begin
          wr_en  = 1'b1;
          swr_en = 1'b1;
          if (down_after_r) begin
            s_nxt  = s0_r;
            st_nxt = ibhq_pkg::ST_DN_LOAD;
          end else begin
            st_nxt = ibhq_pkg::ST_DONE;
          end
        end else begin
          ra_addr = (s_r - SW'(1)) >> 1;
          st_nxt  = ibhq_pkg::ST_UP_CMP;
        end
      end
      ibhq_pkg::ST_UP_CMP: begin
        wr_en  = 1'b1;
        swr_en = 1'b1;
        if (cmp_above) begin
          // Parent moves down into the hole; the moving entry keeps climbing.
          wr_data  = rd_a_r;
          swr_addr = rd_a_r.id;
          s_nxt    = (s_r - SW'(1)) >> 1;
          st_nxt   = ibhq_pkg::ST_UP_RD;
        end else if (down_after_r) begin
          s_nxt  = s0_r;
          st_nxt = ibhq_pkg::ST_DN_LOAD;
        end else begin
          st_nxt = ibhq_pkg::ST_DONE;
        end
      end
      ibhq_pkg::ST_DN_LOAD: begin
        ra_addr = s_r;
        st_nxt  = ibhq_pkg::ST_DN_GET;
      end
      ibhq_pkg::ST_DN_GET: begin
        cur_nxt = rd_a_r;
        st_nxt  = ibhq_pkg::ST_DN_RD;
      end
      ibhq_pkg::ST_DN_RD: begin
        if (lchild >= LW'(count_r)) begin
          wr_en  = 1'b1;
          swr_en = 1'b1;
          st_nxt = ibhq_pkg::ST_DONE;
        end else begin
          ra_addr = SW'(lchild);
          rb_addr = SW'(lchild + LW'(1));
          st_nxt  = ibhq_pkg::ST_DN_SEL;
        end
      end
      ibhq_pkg::ST_DN_SEL: begin
        ch_nxt    = pick_right ? rd_b_r : rd_a_r;
        chidx_nxt = pick_right ? SW'(lchild + LW'(1)) : SW'(lchild);
        st_nxt    = ibhq_pkg::ST_DN_CMP;
      end
      ibhq_pkg::ST_DN_CMP: begin
        wr_en  = 1'b1;
        swr_en = 1'b1;
        if (cmp_above) begin
          wr_data  = ch_r;
          swr_addr = ch_r.id;
          s_nxt    = chidx_r;
          st_nxt   = ibhq_pkg::ST_DN_RD;
        end else begin
          st_nxt = ibhq_pkg::ST_DONE;
        end
      end
      ibhq_pkg::ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load = 1'b1;
          st_nxt   = ibhq_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt = ibhq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ibhq_pkg::ST_IDLE;
      count_r     <= '0;
      present_r   <= '0;
      cap_r       <= ibhq_pkg::CAP_BITS'(64);
      min_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (ibhq_pkg::cfg_reg_t'(cfg_index))
          ibhq_pkg::REG_CAPACITY: cap_r <= cfg_wdata;
          ibhq_pkg::REG_MIN_HEAP: min_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    id_r         <= id_nxt;
    key_r        <= key_nxt;
    s_r          <= s_nxt;
    s0_r         <= s0_nxt;
    chidx_r      <= chidx_nxt;
    cur_r        <= cur_nxt;
    ch_r         <= ch_nxt;
    down_after_r <= down_after_nxt;
    ok_r         <= ok_nxt;
    fid_r        <= fid_nxt;
    fkey_r       <= fkey_nxt;
    // The top entry is mirrored so that outputs and delete top need no extra read.
    if (wr_en && (wr_addr == '0)) begin
      top_r <= wr_data;
    end
    if (out_load) begin
      out_ok_r        <= ok_r;
      out_fid_r       <= fid_r;
      out_fkey_r      <= ibhq_pkg::PORT_KEY_BITS'(fkey_r);
      out_top_valid_r <= (count_r != '0);
      out_top_id_r    <= (count_r != '0) ? top_r.id : '0;
      out_top_key_r   <= (count_r != '0) ? ibhq_pkg::PORT_KEY_BITS'(top_r.key) : '0;
      out_count_r     <= ibhq_pkg::COUNT_OUT_BITS'(count_r);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.ok          = out_ok_r;
  assign out_chan.found_id    = out_fid_r;
  assign out_chan.found_key   = out_fkey_r;
  assign out_chan.top_valid   = out_top_valid_r;
  assign out_chan.top_id      = out_top_id_r;
  assign out_chan.top_key     = out_top_key_r;
  assign out_chan.entry_count = out_count_r;

`include "indexed_binary_heap_queue_unit_macros.svh"

  `IBHQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(MAX_ENTRIES))
  `IBHQ_ASSERT_NXT(a_accept_busy, in_chan.valid && in_chan.ready, st_r == ibhq_pkg::ST_LOOK)
  `IBHQ_ASSERT_NXT(a_done_emits, out_load, out_valid_r && st_r == ibhq_pkg::ST_IDLE)
  `IBHQ_ASSERT_IMP(a_count_present, 1'b1,
                   32'($countones(present_r)) == 32'(count_r) || st_r != ibhq_pkg::ST_IDLE)

endmodule

@@ verif/indexed_binary_heap_queue_unit_tb.sv @@
`timescale 1ns / 1ps

module indexed_binary_heap_queue_unit_tb;

  localparam logic [ibhq_pkg::KIND_BITS-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [ibhq_pkg::KIND_BITS-1:0] KIND_SPARE_HI = 3'd7;
  localparam int HEAP_SLOTS = 64;

  typedef struct packed {
    logic [ibhq_pkg::KIND_BITS-1:0]      kind;
    logic [ibhq_pkg::ID_BITS-1:0]        entry_id;
    logic signed [31:0]                  key;
  } op_t;

  typedef struct packed {
    logic                                ok;
    logic [ibhq_pkg::ID_BITS-1:0]        found_id;
    logic signed [31:0]                  found_key;
    logic                                top_valid;
    logic [ibhq_pkg::ID_BITS-1:0]        top_id;
    logic signed [31:0]                  top_key;
    logic [ibhq_pkg::COUNT_OUT_BITS-1:0] entry_count;
  } answer_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ibhq_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [ibhq_pkg::CAP_BITS-1:0] cfg_wdata;

  ibhq_in_if  in_chan ();
  ibhq_out_if out_chan ();

  indexed_binary_heap_queue_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow of the heap, kept in step with every accepted transfer.
  logic signed [31:0] heap_key [HEAP_SLOTS];
  logic [ibhq_pkg::ID_BITS-1:0] heap_id [HEAP_SLOTS];
  int unsigned slot_of [ibhq_pkg::ID_SPACE];
  bit present [ibhq_pkg::ID_SPACE];
  int unsigned fill;
  int unsigned cap_reg;
  bit min_order;

  op_t pending_ops[$];
  answer_t expected_answers[$];
  int errors;
  int ops_taken;
  int ok_seen;
  int kind_seen [8];
  int max_fill;
  bit calm;
  bit want_hold;
  bit hold_used;
  int stall_left;
  bit took;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit outranks(logic signed [31:0] a, logic signed [31:0] b);
    return min_order ? (a < b) : (b < a);
  endfunction

  task automatic swap_slots(int unsigned i, int unsigned j);
    logic signed [31:0] k;
    logic [ibhq_pkg::ID_BITS-1:0] d;
    k = heap_key[i]; d = heap_id[i];
    heap_key[i] = heap_key[j]; heap_id[i] = heap_id[j];
    heap_key[j] = k; heap_id[j] = d;
    slot_of[heap_id[i]] = i;
    slot_of[heap_id[j]] = j;
  endtask

  task automatic sift_up(int unsigned s);
    int unsigned p;
    while (s > 0 && s < fill) begin
      p = (s - 1) / 2;
      if (!outranks(heap_key[s], heap_key[p])) break;
      swap_slots(s, p);
      s = p;
    end
  endtask

  task automatic sift_down(int unsigned s);
    int unsigned l, c;
    while (s < fill) begin
      l = 2 * s + 1;
      if (l >= fill) break;
      c = l;
      // On equal children the right one is taken.
      if (l + 1 < fill) c = outranks(heap_key[l], heap_key[l + 1]) ? l : l + 1;
      if (!outranks(heap_key[c], heap_key[s])) break;
      swap_slots(s, c);
      s = c;
    end
  endtask

  task automatic take_slot(int unsigned s);
    int unsigned last;
    last = fill - 1;
    present[heap_id[s]] = 1'b0;
    if (s != last) begin
      heap_key[s] = heap_key[last];
      heap_id[s] = heap_id[last];
      slot_of[heap_id[s]] = s;
    end
    fill = last;
    if (s < fill) begin
      sift_up(s);
      sift_down(s);
    end
  endtask

  task automatic heap_apply(input op_t op, output answer_t ans);
    int unsigned eff_cap;
    bit id_ok;
    logic signed [31:0] old;
    ans = '0;
    eff_cap = (cap_reg > HEAP_SLOTS) ? HEAP_SLOTS : cap_reg;
    id_ok = op.entry_id < eff_cap;
    case (op.kind)
      ibhq_pkg::KIND_INSERT: begin
        if (id_ok && !present[op.entry_id] && fill < HEAP_SLOTS) begin
          heap_key[fill] = op.key;
          heap_id[fill] = op.entry_id;
          slot_of[op.entry_id] = fill;
          present[op.entry_id] = 1'b1;
          fill++;
          sift_up(fill - 1);
          ans.ok = 1'b1;
        end
      end
      ibhq_pkg::KIND_CHANGE: begin
        if (id_ok && present[op.entry_id]) begin
          old = heap_key[slot_of[op.entry_id]];
          heap_key[slot_of[op.entry_id]] = op.key;
          if (outranks(op.key, old)) sift_up(slot_of[op.entry_id]);
          else sift_down(slot_of[op.entry_id]);
          ans.ok = 1'b1;
        end
      end
      ibhq_pkg::KIND_REMOVE: begin
        if (id_ok && present[op.entry_id]) begin
          take_slot(slot_of[op.entry_id]);
          ans.ok = 1'b1;
        end
      end
      ibhq_pkg::KIND_DELTOP: begin
        if (fill > 0) begin
          ans.found_id = heap_id[0];
          ans.found_key = heap_key[0];
          take_slot(0);
          ans.ok = 1'b1;
        end
      end
      ibhq_pkg::KIND_READ: begin
        if (id_ok && present[op.entry_id]) begin
          ans.found_key = heap_key[slot_of[op.entry_id]];
          ans.ok = 1'b1;
        end
      end
      ibhq_pkg::KIND_PEEK: ans.ok = fill > 0;
      default: ;
    endcase
    ans.top_valid = fill > 0;
    ans.top_id = (fill > 0) ? heap_id[0] : '0;
    ans.top_key = (fill > 0) ? heap_key[0] : '0;
    ans.entry_count = fill[ibhq_pkg::COUNT_OUT_BITS-1:0];
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Output check and input acceptance at the rising edge.
  always @(posedge clk) begin
    answer_t want, got;
    op_t op;
    if (rst_n) begin
      took <= in_chan.valid && in_chan.ready;
      if (out_chan.valid && out_chan.ready) begin
        got.ok = out_chan.ok;
        got.found_id = out_chan.found_id;
        got.found_key = out_chan.found_key;
        got.top_valid = out_chan.top_valid;
        got.top_id = out_chan.top_id;
        got.top_key = out_chan.top_key;
        got.entry_count = out_chan.entry_count;
        if (expected_answers.size() == 0) begin
          $display("%0t: result transfer with nothing expected", $time);
          errors++;
        end else begin
          want = expected_answers.pop_front();
          check_field("ok", want.ok, got.ok);
          check_field("found_id", want.found_id, got.found_id);
          check_field("found_key", want.found_key, got.found_key);
          check_field("top_valid", want.top_valid, got.top_valid);
          check_field("top_id", want.top_id, got.top_id);
          check_field("top_key", want.top_key, got.top_key);
          check_field("entry_count", want.entry_count, got.entry_count);
          if (want.ok) ok_seen++;
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        op.kind = in_chan.kind;
        op.entry_id = in_chan.entry_id;
        op.key = in_chan.key;
        heap_apply(op, want);
        expected_answers.push_back(want);
        ops_taken++;
        kind_seen[op.kind]++;
        if (fill > max_fill) max_fill = fill;
      end
    end else begin
      took <= 1'b0;
    end
  end

  // Sender: holds an item until its transfer, otherwise offers the next one.
  always @(negedge clk) begin
    op_t op;
    if (rst_n && (took || !in_chan.valid)) begin
      if (pending_ops.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
        op = pending_ops.pop_front();
        in_chan.valid <= 1'b1;
        in_chan.kind <= op.kind;
        in_chan.entry_id <= op.entry_id;
        in_chan.key <= op.key;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off on request.
  always @(negedge clk) begin
    if (want_hold && !hold_used) begin
      hold_used <= 1'b1;
      stall_left <= 400;
      out_chan.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= calm || $urandom_range(99) >= 32;
    end
  end

  task automatic queue_op(logic [ibhq_pkg::KIND_BITS-1:0] kind, int unsigned id,
                          logic signed [31:0] key);
    op_t op;
    op.kind = kind;
    op.entry_id = id[ibhq_pkg::ID_BITS-1:0];
    op.key = key;
    pending_ops.push_back(op);
  endtask

  task automatic wait_drained();
    while (pending_ops.size() > 0 || expected_answers.size() > 0 || in_chan.valid)
      @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(ibhq_pkg::cfg_reg_t idx, int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[ibhq_pkg::CAP_BITS-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == ibhq_pkg::REG_CAPACITY) cap_reg = value;
    else min_order = value[0];
  endtask

  function automatic logic signed [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return $signed($urandom_range(16)) - 8;
    if (r < 50) return 32'sh7fffffff - $urandom_range(2);
    if (r < 60) return 32'sh80000000 + $urandom_range(2);
    return $urandom;
  endfunction

  // mode 0 balanced, 1 mostly inserts, 2 mostly removals
  task automatic random_phase(int n, int mode);
    int unsigned r, id_top;
    logic [ibhq_pkg::KIND_BITS-1:0] kind;
    id_top = (cap_reg == 0) ? 3 : ((cap_reg > HEAP_SLOTS) ? HEAP_SLOTS : cap_reg) - 1;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (mode == 1) r = (r < 60) ? 0 : r;
      if (mode == 2) r = (r < 50) ? 50 : r;
      if (r < 35) kind = ibhq_pkg::KIND_INSERT;
      else if (r < 50) kind = ibhq_pkg::KIND_CHANGE;
      else if (r < 63) kind = ibhq_pkg::KIND_REMOVE;
      else if (r < 78) kind = ibhq_pkg::KIND_DELTOP;
      else if (r < 89) kind = ibhq_pkg::KIND_READ;
      else if (r < 97) kind = ibhq_pkg::KIND_PEEK;
      else kind = r[0] ? KIND_SPARE_LO : KIND_SPARE_HI;
      if ($urandom_range(99) < 90) queue_op(kind, $urandom_range(id_top), pick_key());
      else queue_op(kind, $urandom_range(63), pick_key());
    end
    wait_drained();
  endtask

  initial begin
    errors = 0; ops_taken = 0; ok_seen = 0; max_fill = 0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    calm = 1'b0; want_hold = 1'b0; hold_used = 1'b0; stall_left = 0;
    cap_reg = 64; min_order = 1'b1; fill = 0;
    foreach (present[i]) present[i] = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = ibhq_pkg::REG_CAPACITY; cfg_wdata = '0;
    in_chan.valid = 1'b0; in_chan.kind = ibhq_pkg::KIND_PEEK;
    in_chan.entry_id = '0; in_chan.key = '0;
    out_chan.ready = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty queue, extreme keys and ids, duplicates, spare kinds.
    queue_op(ibhq_pkg::KIND_DELTOP, 0, 0);
    queue_op(ibhq_pkg::KIND_PEEK, 0, 0);
    queue_op(ibhq_pkg::KIND_READ, 5, 0);
    queue_op(ibhq_pkg::KIND_INSERT, 0, 32'sh7fffffff);
    queue_op(ibhq_pkg::KIND_INSERT, 63, 32'sh80000000);
    queue_op(ibhq_pkg::KIND_INSERT, 63, 1);
    queue_op(ibhq_pkg::KIND_INSERT, 42, 7);
    queue_op(ibhq_pkg::KIND_INSERT, 21, 7);
    queue_op(ibhq_pkg::KIND_CHANGE, 63, 32'sh7fffffff);
    queue_op(ibhq_pkg::KIND_CHANGE, 0, -5);
    queue_op(ibhq_pkg::KIND_CHANGE, 9, 3);
    queue_op(ibhq_pkg::KIND_READ, 42, 0);
    queue_op(ibhq_pkg::KIND_REMOVE, 21, 0);
    queue_op(ibhq_pkg::KIND_REMOVE, 21, 0);
    queue_op(KIND_SPARE_LO, 0, 0);
    queue_op(KIND_SPARE_HI, 63, -1);
    queue_op(ibhq_pkg::KIND_PEEK, 0, 0);
    queue_op(ibhq_pkg::KIND_DELTOP, 0, 0);
    queue_op(ibhq_pkg::KIND_DELTOP, 0, 0);
    queue_op(ibhq_pkg::KIND_DELTOP, 0, 0);
    queue_op(ibhq_pkg::KIND_DELTOP, 0, 0);
    wait_drained();

    // Fill the heap completely in max order, then overflow and drain in part.
    write_reg(ibhq_pkg::REG_MIN_HEAP, 0);
    for (int i = 0; i < 64; i++) queue_op(ibhq_pkg::KIND_INSERT, i, pick_key());
    queue_op(ibhq_pkg::KIND_INSERT, 5, 0);
    wait_drained();
    random_phase(150, 0);

    // Receiver holds off while the sender keeps offering.
    calm = 1'b1;
    want_hold = 1'b1;
    random_phase(200, 0);
    calm = 1'b0;

    // Order flipped with entries held, then raised and lowered capacities.
    write_reg(ibhq_pkg::REG_MIN_HEAP, 1);
    random_phase(150, 2);
    write_reg(ibhq_pkg::REG_CAPACITY, 127);
    random_phase(150, 1);
    write_reg(ibhq_pkg::REG_CAPACITY, 1);
    random_phase(80, 0);
    write_reg(ibhq_pkg::REG_CAPACITY, 0);
    random_phase(50, 0);
    write_reg(ibhq_pkg::REG_CAPACITY, 12);
    write_reg(ibhq_pkg::REG_MIN_HEAP, 0);
    random_phase(200, 1);
    random_phase(150, 2);
    write_reg(ibhq_pkg::REG_CAPACITY, 64);
    write_reg(ibhq_pkg::REG_MIN_HEAP, 1);
    random_phase(200, 1);
    write_reg(ibhq_pkg::REG_CAPACITY, $urandom_range(2, 63));
    write_reg(ibhq_pkg::REG_MIN_HEAP, $urandom_range(1));
    random_phase(150, 0);
    random_phase(100, 2);

    $display("tb: %0d operations, %0d succeeded, peak occupancy %0d, capacities 0 to 127",
             ops_taken, ok_seen, max_fill);
    $display("tb: per kind insert %0d change %0d remove %0d deltop %0d read %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             " peek %0d spare %0d", kind_seen[5], kind_seen[6] + kind_seen[7]);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ indexed_binary_heap_queue_unit.f @@
+incdir+design
design/ibhq_pkg.sv
design/ibhq_in_if.sv
design/ibhq_out_if.sv
design/indexed_binary_heap_queue_unit.sv
verif/indexed_binary_heap_queue_unit_tb.sv
